// File: sv/smmd_pkg.sv
// Shared types, constants and helper functions for the source map mappings decoder.
// Used by smmd_core, source_map_mapping_decoder and smmd_checker; depends on nothing.
package smmd_pkg;

    localparam int TEXT_W         = 8;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;
    localparam int COUNT_W        = 16;
    localparam int VALUE_W        = 32;
    localparam int DIGIT_BITS     = 5;
    localparam int CONT_BIT       = 5;
    localparam int MAX_VLQ_DIGITS = 7;
    localparam int DIGIT_CNT_W    = 3;
    localparam int SHAMT_W        = 5;
    localparam int FIELD_SLOTS    = 4;
    localparam int FIELD_IDX_W    = 2;
    localparam int SEG_CNT_W      = 3;
    localparam int SEG_MIN        = 1;
    localparam int SEG_SRC        = 4;
    localparam int SEG_FULL       = 5;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_COUNT   = 1'b1;

    // Characters with a meaning of their own.
    localparam logic [TEXT_W-1:0] CH_TERM  = 8'h00;
    localparam logic [TEXT_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [TEXT_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [TEXT_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [TEXT_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [TEXT_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [TEXT_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [TEXT_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [TEXT_W-1:0] CH_NINE  = 8'h39;
    localparam logic [TEXT_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [TEXT_W-1:0] CH_SLASH = 8'h2F;

    // Output word layout, lowest bit first.
    localparam int STATUS_W         = 3;
    localparam int OFS_GEN_LINE     = 3;
    localparam int OFS_GEN_COLUMN   = 35;
    localparam int OFS_HAS_SOURCE   = 67;
    localparam int OFS_SRC_INDEX    = 68;
    localparam int OFS_ORIG_LINE    = 84;
    localparam int OFS_ORIG_COLUMN  = 116;
    localparam int OFS_HAS_NAME     = 148;
    localparam int OFS_SYM_INDEX    = 149;
    localparam int PAYLOAD_W        = 165;
    localparam int TDATA_W          = 168;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_BAD_CHAR     = 3'd1,
        ST_TRUNCATED    = 3'd2,
        ST_SOURCE_RANGE = 3'd3,
        ST_NAME_RANGE   = 3'd4,
        ST_TOO_LONG     = 3'd5
    } t_status;

    typedef enum logic {
        KIND_MAPPING = 1'b0,
        KIND_DONE    = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic                 last_of_item;
        t_status              status;
        logic [VALUE_W-1:0]   gen_line;
        logic [VALUE_W-1:0]   gen_column;
        logic                 has_source;
        logic [COUNT_W-1:0]   src_index;
        logic [VALUE_W-1:0]   orig_line;
        logic [VALUE_W-1:0]   orig_column;
        logic                 has_name;
        logic [COUNT_W-1:0]   sym_index;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_core_out;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_digit;

    function automatic t_digit digit_of(input logic [TEXT_W-1:0] c);
        t_digit d;
        d.ok  = 1'b1;
        d.val = '0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d.val = 6'(c - CH_UPPER_A);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d.val = 6'(c - CH_LOWER_A + 8'd26);
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            d.val = 6'(c - CH_ZERO + 8'd52);
        end else if (c == CH_PLUS) begin
            d.val = 6'd62;
        end else if (c == CH_SLASH) begin
            d.val = 6'd63;
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    function automatic logic [TDATA_W-1:0] pack_tdata(input t_result r);
        return {{(TDATA_W - PAYLOAD_W){1'b0}}, r.sym_index, r.has_name, r.orig_column,
                r.orig_line, r.src_index, r.has_source, r.gen_column, r.gen_line,
                r.status};
    endfunction

endpackage

// File: sv/smmd_core.sv
// Per-character decode: VLQ digit accumulation, segment assembly, base update and error status.
// Depends on smmd_pkg; instantiated by source_map_mapping_decoder.
module smmd_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [smmd_pkg::TEXT_W-1:0]   i_char,
    input  logic [smmd_pkg::COUNT_W-1:0]  i_source_count,
    input  logic [smmd_pkg::COUNT_W-1:0]  i_name_count,
    output smmd_pkg::t_core_out           o_out
);
    import smmd_pkg::*;

    logic [VALUE_W-1:0]     r_line, n_line;
    logic [VALUE_W-1:0]     r_col_base, n_col_base;
    logic [COUNT_W-1:0]     r_src_base, n_src_base;
    logic [VALUE_W-1:0]     r_oline_base, n_oline_base;
    logic [VALUE_W-1:0]     r_ocol_base, n_ocol_base;
    logic [COUNT_W-1:0]     r_name_base, n_name_base;
    logic [VALUE_W-1:0]     r_accum, n_accum;
    logic [DIGIT_CNT_W-1:0] r_digits, n_digits;
    logic [SEG_CNT_W-1:0]   r_nfields, n_nfields;
    t_status                r_err, n_err;
    logic [VALUE_W-1:0]     r_field [FIELD_SLOTS];

    t_digit                 dg;
    logic                   is_term, is_sep, is_semi;
    logic [SHAMT_W-1:0]     shamt;
    logic [VALUE_W-1:0]     acc_new, mag, value;
    logic                   field_we;
    logic                   seg_try, flag_set, rec_ok;
    logic [SEG_CNT_W-1:0]   seg_n;
    t_status                flag_code;
    logic [VALUE_W-1:0]     gcol, src_sum, oline_sum, ocol_sum, name_sum;
    logic                   src_bad, name_bad;
    t_result                rec, done;

    always_comb begin
        dg      = digit_of(i_char);
        is_term = (i_char == CH_TERM);
        is_semi = (i_char == CH_SEMI);
        is_sep  = is_semi || (i_char == CH_COMMA);
        // Each digit lands five bits above the previous one.
        shamt   = ({2'b00, r_digits} << 2) + {2'b00, r_digits};
        acc_new = r_accum | (VALUE_W'(dg.val[DIGIT_BITS-1:0]) << shamt);
        mag     = {1'b0, acc_new[VALUE_W-1:1]};
        value   = acc_new[0] ? (~mag + 1'b1) : mag;

        gcol      = r_col_base + r_field[0];
        src_sum   = {{(VALUE_W - COUNT_W){1'b0}}, r_src_base} + r_field[1];
        src_bad   = src_sum >= {{(VALUE_W - COUNT_W){1'b0}}, i_source_count};
        oline_sum = r_oline_base + r_field[2];
        ocol_sum  = r_ocol_base + r_field[3];
        name_sum  = {{(VALUE_W - COUNT_W){1'b0}}, r_name_base} + value;
        name_bad  = name_sum >= {{(VALUE_W - COUNT_W){1'b0}}, i_name_count};
    end

    always_comb begin
        n_line       = r_line;
        n_col_base   = r_col_base;
        n_src_base   = r_src_base;
        n_oline_base = r_oline_base;
        n_ocol_base  = r_ocol_base;
        n_name_base  = r_name_base;
        n_accum      = r_accum;
        n_digits     = r_digits;
        n_nfields    = r_nfields;
        field_we     = 1'b0;
        seg_try      = 1'b0;
        seg_n        = r_nfields;
        flag_set     = 1'b0;
        flag_code    = ST_OK;
        rec_ok       = 1'b0;
        rec          = '0;

        // After the first error only the terminator does anything.
        if (r_err == ST_OK) begin
            if (is_term || is_sep) begin
                n_nfields = '0;
                if (r_digits != '0) begin
                    flag_set  = 1'b1;
                    flag_code = ST_TRUNCATED;
                end else if (r_nfields == SEG_CNT_W'(SEG_MIN)
                          || r_nfields == SEG_CNT_W'(SEG_SRC)) begin
                    seg_try = 1'b1;
                end else if (r_nfields != '0) begin
                    flag_set  = 1'b1;
                    flag_code = ST_TRUNCATED;
                end
            end else if (!dg.ok) begin
                flag_set  = 1'b1;
                flag_code = ST_BAD_CHAR;
            end else if (r_digits >= DIGIT_CNT_W'(MAX_VLQ_DIGITS)) begin
                flag_set  = 1'b1;
                flag_code = ST_TOO_LONG;
            end else begin
                n_accum  = acc_new;
                n_digits = r_digits + 1'b1;
                if (!dg.val[CONT_BIT]) begin
                    n_accum  = '0;
                    n_digits = '0;
                    if (r_nfields == SEG_CNT_W'(FIELD_SLOTS)) begin
                        // The fifth value completes the segment straight away.
                        n_nfields = '0;
                        seg_try   = 1'b1;
                        seg_n     = SEG_CNT_W'(SEG_FULL);
                    end else begin
                        field_we  = 1'b1;
                        n_nfields = r_nfields + 1'b1;
                    end
                end
            end
        end

        if (seg_try) begin
            n_col_base = gcol;
            if (seg_n >= SEG_CNT_W'(SEG_SRC) && src_bad) begin
                flag_set  = 1'b1;
                flag_code = ST_SOURCE_RANGE;
            end else if (seg_n == SEG_CNT_W'(SEG_FULL) && name_bad) begin
                flag_set  = 1'b1;
                flag_code = ST_NAME_RANGE;
            end else begin
                rec_ok         = 1'b1;
                rec.kind       = KIND_MAPPING;
                rec.status     = ST_OK;
                rec.gen_line   = r_line;
                rec.gen_column = gcol;
                if (seg_n >= SEG_CNT_W'(SEG_SRC)) begin
                    n_src_base       = src_sum[COUNT_W-1:0];
                    n_oline_base     = oline_sum;
                    n_ocol_base      = ocol_sum;
                    rec.has_source   = 1'b1;
                    rec.src_index    = src_sum[COUNT_W-1:0];
                    rec.orig_line    = oline_sum + 1'b1;
                    rec.orig_column  = ocol_sum;
                end
                if (seg_n == SEG_CNT_W'(SEG_FULL)) begin
                    n_name_base    = name_sum[COUNT_W-1:0];
                    rec.has_name   = 1'b1;
                    rec.sym_index  = name_sum[COUNT_W-1:0];
                end
            end
        end

        n_err = flag_set ? flag_code : r_err;

        if (is_semi && r_err == ST_OK && !flag_set) begin
            n_line     = r_line + 1'b1;
            n_col_base = '0;
        end

        if (is_term) begin
            n_line       = VALUE_W'(1);
            n_col_base   = '0;
            n_src_base   = '0;
            n_oline_base = '0;
            n_ocol_base  = '0;
            n_name_base  = '0;
            n_accum      = '0;
            n_digits     = '0;
            n_nfields    = '0;
            n_err        = ST_OK;
        end
    end

    always_comb begin
        done              = '0;
        done.kind         = KIND_DONE;
        done.last_of_item = 1'b1;
        done.status       = flag_set ? flag_code : r_err;

        o_out = '0;
        if (is_term) begin
            o_out.cnt  = rec_ok ? 2'd2 : 2'd1;
            o_out.res0 = rec_ok ? rec : done;
            o_out.res1 = done;
        end else begin
            o_out.cnt               = {1'b0, rec_ok};
            o_out.res0              = rec;
            o_out.res0.last_of_item = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line       <= VALUE_W'(1);
            r_col_base   <= '0;
            r_src_base   <= '0;
            r_oline_base <= '0;
            r_ocol_base  <= '0;
            r_name_base  <= '0;
            r_accum      <= '0;
            r_digits     <= '0;
            r_nfields    <= '0;
            r_err        <= ST_OK;
        end else if (i_fire) begin
            r_line       <= n_line;
            r_col_base   <= n_col_base;
            r_src_base   <= n_src_base;
            r_oline_base <= n_oline_base;
            r_ocol_base  <= n_ocol_base;
            r_name_base  <= n_name_base;
            r_accum      <= n_accum;
            r_digits     <= n_digits;
            r_nfields    <= n_nfields;
            r_err        <= n_err;
        end
    end

    // Values of the segment being collected; read only at slots the segment has filled.
    always_ff @(posedge i_clk) begin
        if (i_fire && field_we) begin
            r_field[r_nfields[FIELD_IDX_W-1:0]] <= value;
        end
    end

endmodule

// File: sv/source_map_mapping_decoder.sv
// Top level of the source map mappings decoder: stream ports, configuration registers,
// input queue and result buffer. Depends on smmd_pkg and smmd_core.
//
//  channel   | direction | word                        | accepted when
//  ----------+-----------+-----------------------------+-----------------------------
//  s_axis    | in        | one mappings character      | s_axis_tvalid & s_axis_tready
//  m_axis    | out       | mapping record or done word | m_axis_tvalid & m_axis_tready
//  i_cfg     | in        | register index and value    | i_cfg_valid & o_cfg_ready
//
// One character is decoded per cycle while m_axis takes every word; a word passes through
// the input queue and then the result buffer before it leaves. A terminator that closes a
// segment gives two words, which keeps the decoder busy while the result buffer drains.
// A two-word input queue keeps s_axis_tready registered; when m_axis stalls the queue
// fills and tready falls. Reset is synchronous and needs no clearing pass.
module source_map_mapping_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [smmd_pkg::TEXT_W-1:0]      s_axis_tdata,  // [7:0] text_char
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] status, [34:3] gen_line, [66:35] gen_column, [67] has_source,
    // [83:68] src_index, [115:84] orig_line, [147:116] orig_column,
    // [148] has_name, [164:149] sym_index, [167:165] zero
    output logic [smmd_pkg::TDATA_W-1:0]     m_axis_tdata,
    output logic                             m_axis_tlast,  // last_of_item
    output logic [0:0]                       m_axis_tuser,  // [0] kind
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [smmd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [smmd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import smmd_pkg::*;

    logic [COUNT_W-1:0] r_source_count;
    logic [COUNT_W-1:0] r_name_count;

    logic [TEXT_W-1:0]  r_q0, n_q0;
    logic [TEXT_W-1:0]  r_q1, n_q1;
    logic [1:0]         r_q_cnt, n_q_cnt;

    t_result            r_out0, n_out0;
    t_result            r_out1, n_out1;
    logic [1:0]         r_out_cnt, n_out_cnt;

    logic               push, pop, fire;
    logic [1:0]         remain;
    t_core_out          core_out;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_q_cnt != 2'd2);
    assign m_axis_tvalid = (r_out_cnt != 2'd0);
    assign m_axis_tdata  = pack_tdata(r_out0);
    assign m_axis_tlast  = r_out0.last_of_item;
    assign m_axis_tuser  = r_out0.kind;

    always_comb begin
        push   = s_axis_tvalid && s_axis_tready;
        pop    = m_axis_tvalid && m_axis_tready;
        remain = r_out_cnt - {1'b0, pop};
        // A character is decoded only when its words can go straight into an empty buffer.
        fire   = (r_q_cnt != 2'd0) && (remain == 2'd0);
    end

    smmd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_char         (r_q0),
        .i_source_count (r_source_count),
        .i_name_count   (r_name_count),
        .o_out          (core_out)
    );

    always_comb begin
        n_q0    = r_q0;
        n_q1    = r_q1;
        n_q_cnt = r_q_cnt;
        if (fire && push) begin
            n_q0 = s_axis_tdata;
        end else if (fire) begin
            n_q0    = r_q1;
            n_q_cnt = r_q_cnt - 1'b1;
        end else if (push) begin
            if (r_q_cnt == 2'd0) begin
                n_q0 = s_axis_tdata;
            end else begin
                n_q1 = s_axis_tdata;
            end
            n_q_cnt = r_q_cnt + 1'b1;
        end
    end

    always_comb begin
        n_out0    = r_out0;
        n_out1    = r_out1;
        n_out_cnt = remain;
        if (pop && r_out_cnt == 2'd2) begin
            n_out0 = r_out1;
        end
        if (fire) begin
            n_out0    = core_out.res0;
            n_out1    = core_out.res1;
            n_out_cnt = core_out.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt        <= '0;
            r_out_cnt      <= '0;
            r_source_count <= '0;
            r_name_count   <= '0;
        end else begin
            r_q_cnt   <= n_q_cnt;
            r_out_cnt <= n_out_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SOURCE_COUNT: r_source_count <= i_cfg_data;
                    CFG_NAME_COUNT:   r_name_count   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0   <= n_q0;
        r_q1   <= n_q1;
        r_out0 <= n_out0;
        r_out1 <= n_out1;
    end

endmodule

// File: sv/smmd_checker.sv
// Port-level checks on the result stream of the source map mappings decoder.
// Depends on smmd_pkg; bound to source_map_mapping_decoder at the end of this file.
module smmd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [smmd_pkg::TDATA_W-1:0]  m_axis_tdata,
    input  logic                          m_axis_tlast,
    input  logic [0:0]                    m_axis_tuser
);
    import smmd_pkg::*;

    // A done word always closes the words of its character.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_DONE) |-> m_axis_tlast)
        else $error("done word without tlast");

    // A done word carries only a defined status.
    a_done_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_DONE) |->
            (m_axis_tdata[TDATA_W-1:STATUS_W] == '0
             && m_axis_tdata[STATUS_W-1:0] != 3'd6
             && m_axis_tdata[STATUS_W-1:0] != 3'd7))
        else $error("done word with stray payload or undefined status");

    // Mapping records have status ok and nothing past the generated position without a source.
    a_record_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_MAPPING) |->
            (m_axis_tdata[STATUS_W-1:0] == ST_OK
             && (m_axis_tdata[OFS_HAS_SOURCE]
                 || m_axis_tdata[TDATA_W-1:OFS_SRC_INDEX] == '0)))
        else $error("malformed mapping record");

    // A stalled word stays offered unchanged.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("result word changed while stalled");

endmodule

bind source_map_mapping_decoder smmd_checker u_smmd_checker (.*);

// File: tb/testbench.sv
// Self-checking bench for source_map_mapping_decoder: mappings text goes in one character per
// word, and every record and done word is checked against a predictor of the decoder.
// Depends on smmd_pkg and the decoder RTL only.
module testbench;
    import smmd_pkg::*;

    class mapping_scoreboard;
        logic [COUNT_W-1:0] src_limit;
        logic [COUNT_W-1:0] name_limit;

        logic [VALUE_W-1:0] line_no;
        logic [VALUE_W-1:0] col_acc;
        logic [COUNT_W-1:0] src_acc;
        logic [VALUE_W-1:0] oline_acc;
        logic [VALUE_W-1:0] ocol_acc;
        logic [COUNT_W-1:0] name_acc;
        logic [VALUE_W-1:0] vlq_acc;
        int unsigned        ndigits;
        logic [VALUE_W-1:0] seg_val [5];
        int unsigned        nvals;
        t_status            err;

        t_result            expected_q [$];
        int unsigned        mismatches;
        int unsigned        failures;

        function new();
            src_limit  = '0;
            name_limit = '0;
            mismatches = 0;
            failures   = 0;
            clear();
        endfunction

        function void clear();
            line_no   = 32'd1;
            col_acc   = '0;
            src_acc   = '0;
            oline_acc = '0;
            ocol_acc  = '0;
            name_acc  = '0;
            vlq_acc   = '0;
            ndigits   = 0;
            nvals     = 0;
            err       = ST_OK;
            foreach (seg_val[i]) seg_val[i] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_SOURCE_COUNT) begin
                src_limit = val;
            end else if (idx == CFG_NAME_COUNT) begin
                name_limit = val;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void raise(t_status code);
            if (err == ST_OK) err = code;
        endfunction

        function int digit_value(logic [TEXT_W-1:0] c);
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return int'(c - CH_UPPER_A);
            if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return int'(c - CH_LOWER_A) + 26;
            if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO) + 52;
            if (c == CH_PLUS) return 62;
            if (c == CH_SLASH) return 63;
            return -1;
        endfunction

        // Adds a segment of n values to the running bases and queues its record.
        function bit add_record(int unsigned n);
            t_result            r;
            logic [VALUE_W-1:0] s;
            logic [VALUE_W-1:0] nm;
            r  = '0;
            s  = '0;
            nm = '0;
            col_acc      = col_acc + seg_val[0];
            r.kind       = KIND_MAPPING;
            r.status     = ST_OK;
            r.gen_line   = line_no;
            r.gen_column = col_acc;
            if (n > 1) begin
                s = {16'h0, src_acc} + seg_val[1];
                if (s >= {16'h0, src_limit}) begin
                    raise(ST_SOURCE_RANGE);
                    return 1'b0;
                end
                src_acc       = s[COUNT_W-1:0];
                oline_acc     = oline_acc + seg_val[2];
                ocol_acc      = ocol_acc + seg_val[3];
                r.has_source  = 1'b1;
                r.src_index   = s[COUNT_W-1:0];
                r.orig_line   = oline_acc + 32'd1;
                r.orig_column = ocol_acc;
                if (n > 4) begin
                    nm = {16'h0, name_acc} + seg_val[4];
                    if (nm >= {16'h0, name_limit}) begin
                        raise(ST_NAME_RANGE);
                        return 1'b0;
                    end
                    name_acc    = nm[COUNT_W-1:0];
                    r.has_name  = 1'b1;
                    r.sym_index = nm[COUNT_W-1:0];
                end
            end
            expected_q.push_back(r);
            return 1'b1;
        endfunction

        function bit close_segment();
            int unsigned n;
            n     = nvals;
            nvals = 0;
            if (ndigits != 0) begin
                raise(ST_TRUNCATED);
                return 1'b0;
            end
            if (n == 1 || n == 4 || n == 5) return add_record(n);
            if (n != 0) raise(ST_TRUNCATED);
            return 1'b0;
        endfunction

        function void note_char(logic [TEXT_W-1:0] c);
            int                 d;
            int unsigned        made;
            logic [VALUE_W-1:0] raw;
            logic [VALUE_W-1:0] v;
            t_result            r;
            made = 0;
            if (c == CH_TERM) begin
                if (err == ST_OK) made = close_segment();
                r        = '0;
                r.kind   = KIND_DONE;
                r.status = err;
                expected_q.push_back(r);
                made++;
                clear();
            end else if (err == ST_OK) begin
                if (c == CH_SEMI || c == CH_COMMA) begin
                    made = close_segment();
                    if (err == ST_OK && c == CH_SEMI) begin
                        line_no = line_no + 32'd1;
                        col_acc = '0;
                    end
                end else begin
                    d = digit_value(c);
                    if (d < 0) begin
                        raise(ST_BAD_CHAR);
                    end else if (ndigits >= MAX_VLQ_DIGITS) begin
                        raise(ST_TOO_LONG);
                    end else begin
                        vlq_acc = vlq_acc | ((32'(d) & 32'h1f) << ((5 * ndigits) % 32));
                        ndigits++;
                        if (d < 32) begin
                            raw     = vlq_acc;
                            v       = raw[0] ? (32'd0 - (raw >> 1)) : (raw >> 1);
                            vlq_acc = '0;
                            ndigits = 0;
                            if (nvals < 5) seg_val[nvals] = v;
                            nvals++;
                            // A fifth value closes the segment without waiting for a separator.
                            if (nvals >= 5) begin
                                nvals = 0;
                                made  = add_record(5);
                            end
                        end
                    end
                end
            end
            if (made > 0) begin
                r = expected_q.pop_back();
                r.last_of_item = 1'b1;
                expected_q.push_back(r);
            end
        endfunction

        function void check_word(t_result got);
            t_result want;
            bit      bad;
            if (expected_q.size() == 0) begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected word: kind %0d status %0d line %0d col %0d",
                             got.kind, got.status, got.gen_line, got.gen_column);
                return;
            end
            want = expected_q.pop_front();
            bad = (got.kind != want.kind) || (got.last_of_item != want.last_of_item) ||
                  (got.status != want.status) || (got.gen_line != want.gen_line) ||
                  (got.gen_column != want.gen_column) ||
                  (got.has_source != want.has_source) ||
                  (got.src_index != want.src_index) || (got.orig_line != want.orig_line) ||
                  (got.orig_column != want.orig_column) || (got.has_name != want.has_name) ||
                  (got.sym_index != want.sym_index);
            if (bad) begin
                failures++;
                mismatches++;
                if (mismatches <= 10) begin
                    $display("tb: mismatch, expected kind %0d last %0d status %0d gen %0d:%0d",
                             want.kind, want.last_of_item, want.status, want.gen_line,
                             want.gen_column);
                    $display("tb:   expected src %0d/%0d %0d:%0d name %0d/%0d",
                             want.has_source, want.src_index, want.orig_line,
                             want.orig_column, want.has_name, want.sym_index);
                    $display("tb: mismatch, actual   kind %0d last %0d status %0d gen %0d:%0d",
                             got.kind, got.last_of_item, got.status, got.gen_line,
                             got.gen_column);
                    $display("tb:   actual   src %0d/%0d %0d:%0d name %0d/%0d",
                             got.has_source, got.src_index, got.orig_line,
                             got.orig_column, got.has_name, got.sym_index);
                end
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 5000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [TEXT_W-1:0]       s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]      m_axis_tdata;
    logic                    m_axis_tlast;
    logic [0:0]              m_axis_tuser;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    mapping_scoreboard sb = new();

    int          send_idle_pct = 15;
    int          recv_idle_pct = 59;
    int unsigned sent_chars = 0;
    int unsigned quiet_cycles = 0;
    int unsigned phase_end;
    int unsigned strings_done = 0;
    logic [COUNT_W-1:0] cur_src_limit = '0;
    logic [COUNT_W-1:0] cur_name_limit = '0;
    logic [COUNT_W-1:0] gen_src = '0;
    logic [COUNT_W-1:0] gen_name = '0;
    logic [COUNT_W-1:0] src_plan [0:5];
    logic [COUNT_W-1:0] name_plan [0:5];
    t_result            seen_word;

    source_map_mapping_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Samples every handshake at the edge, before this edge's updates take effect.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sent_chars++;
                sb.note_char(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen_word.kind         = t_kind'(m_axis_tuser[0]);
                seen_word.last_of_item = m_axis_tlast;
                seen_word.status       = t_status'(m_axis_tdata[STATUS_W-1:0]);
                seen_word.gen_line     = m_axis_tdata[OFS_GEN_LINE +: VALUE_W];
                seen_word.gen_column   = m_axis_tdata[OFS_GEN_COLUMN +: VALUE_W];
                seen_word.has_source   = m_axis_tdata[OFS_HAS_SOURCE];
                seen_word.src_index    = m_axis_tdata[OFS_SRC_INDEX +: COUNT_W];
                seen_word.orig_line    = m_axis_tdata[OFS_ORIG_LINE +: VALUE_W];
                seen_word.orig_column  = m_axis_tdata[OFS_ORIG_COLUMN +: VALUE_W];
                seen_word.has_name     = m_axis_tdata[OFS_HAS_NAME];
                seen_word.sym_index    = m_axis_tdata[OFS_SYM_INDEX +: COUNT_W];
                sb.check_word(seen_word);
            end
            if (i_cfg_valid && o_cfg_ready) sb.set_reg(i_cfg_index, i_cfg_data);
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [TEXT_W-1:0] b64_char(logic [5:0] v);
        if (v < 6'd26) return CH_UPPER_A + {2'b00, v};
        if (v < 6'd52) return CH_LOWER_A + {2'b00, v - 6'd26};
        if (v < 6'd62) return CH_ZERO + {2'b00, v - 6'd52};
        if (v == 6'd62) return CH_PLUS;
        return CH_SLASH;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            6, 7, 8: return 32'($urandom_range(0, 65535)) - 32'd32768;
            9:       return $urandom();
            default: return 32'($urandom_range(0, 60)) - 32'd30;
        endcase
    endfunction

    task automatic push_char(input logic [TEXT_W-1:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    // Sends nd digits of raw, low digit first, with the continuation bit on all but the last.
    task automatic push_vlq(input logic [34:0] raw, input int unsigned nd);
        int unsigned i;
        for (i = 0; i < nd; i++) push_char(b64_char({(i + 1 < nd), raw[5*i +: 5]}));
    endtask

    task automatic push_value(input logic [VALUE_W-1:0] v);
        logic [32:0] raw;
        logic [32:0] rest;
        int unsigned nd;
        raw  = v[31] ? {32'd0 - v, 1'b1} : {v, 1'b0};
        nd   = 1;
        rest = raw >> 5;
        while (rest != 0) begin
            nd++;
            rest = rest >> 5;
        end
        push_vlq({2'b00, raw}, nd);
    endtask

    task automatic push_segment(input bit with_sep);
        int unsigned        n;
        logic [VALUE_W-1:0] target;
        if ($urandom_range(0, 99) < 94) begin
            n = $urandom_range(0, 9);
            n = (n < 3) ? 1 : (n < 6) ? 4 : 5;
            if (cur_src_limit == 0 && n > 1 && $urandom_range(0, 9) != 0) n = 1;
            if (cur_name_limit == 0 && n == 5 && $urandom_range(0, 9) != 0) n = 4;
            if ($urandom_range(0, 9) == 0) begin
                push_vlq(35'({$urandom(), $urandom()}), $urandom_range(1, MAX_VLQ_DIGITS));
            end else begin
                push_value(rand_value());
            end
            if (n > 1) begin
                target = (cur_src_limit == 0) ? 32'd0 :
                         32'($urandom_range(0, cur_src_limit - 1));
                push_value(target - {16'h0, gen_src});
                gen_src = target[COUNT_W-1:0];
                push_value(rand_value());
                push_value(rand_value());
                if (n > 4) begin
                    target = (cur_name_limit == 0) ? 32'd0 :
                             32'($urandom_range(0, cur_name_limit - 1));
                    push_value(target - {16'h0, gen_name});
                    gen_name = target[COUNT_W-1:0];
                end
            end
            // After five values the next segment may follow with no separator at all.
            if (n == 5 && $urandom_range(0, 3) == 0) return;
        end else begin
            case ($urandom_range(0, 5))
                0: push_char(8'($urandom_range(1, 255)));
                1: push_char(b64_char({1'b1, 5'($urandom_range(0, 31))}));
                2: repeat ($urandom_range(2, 3)) push_value(rand_value());
                3: repeat (MAX_VLQ_DIGITS + 1)
                       push_char(b64_char({1'b1, 5'($urandom_range(0, 31))}));
                4: begin
                    push_value(rand_value());
                    target = $urandom_range(0, 1) ? 32'(cur_src_limit) + $urandom_range(0, 3) :
                             32'hFFFF_FFFF - $urandom_range(0, 3);
                    push_value(target - {16'h0, gen_src});
                    push_value(rand_value());
                    push_value(rand_value());
                end
                default: begin
                    push_value(rand_value());
                    target = (cur_src_limit == 0) ? 32'd0 :
                             32'($urandom_range(0, cur_src_limit - 1));
                    push_value(target - {16'h0, gen_src});
                    gen_src = target[COUNT_W-1:0];
                    push_value(rand_value());
                    push_value(rand_value());
                    target = 32'(cur_name_limit) + $urandom_range(0, 3);
                    push_value(target - {16'h0, gen_name});
                end
            endcase
        end
        if (with_sep) begin
            push_char(($urandom_range(0, 9) < 7) ? CH_COMMA : CH_SEMI);
            if ($urandom_range(0, 19) == 0) push_char(CH_COMMA);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers change only once the decoder has gone quiet.
    task automatic configure(input logic [COUNT_W-1:0] srcs, input logic [COUNT_W-1:0] names);
        drain();
        repeat (8) @(posedge i_clk);
        cfg_write(CFG_SOURCE_COUNT, srcs);
        cfg_write(CFG_NAME_COUNT, names);
        cur_src_limit  = srcs;
        cur_name_limit = names;
    endtask

    initial begin
        int unsigned phase;
        int unsigned nseg;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_plan  = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 65535)), 16'hFFFF, 16'd6};
        name_plan = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 65535)), 16'd0, 16'd3};

        configure(16'd4, 16'd2);
        // A terminator that closes a pending segment gives a record and then the done word.
        push_text("AAAA");
        push_char(CH_TERM);
        push_text("A;,AACACD");
        push_char(CH_TERM);
        push_text("g,");
        push_char(CH_TERM);
        push_text("gggggggg");
        push_char(CH_TERM);
        push_char(8'hFF);
        push_text("AC,");
        push_char(CH_TERM);
        push_text("AC,");
        push_char(CH_TERM);
        push_text("AIAA");
        push_char(CH_TERM);
        push_text("AAAAE");
        push_char(CH_TERM);
        push_char(8'h80);
        push_char(CH_TERM);

        for (phase = 0; phase < 6; phase++) begin
            configure(src_plan[phase], name_plan[phase]);
            send_idle_pct = (phase < 2) ? 15 : (phase < 4) ? 59 : 0;
            recv_idle_pct = (phase < 2) ? 59 : (phase < 4) ? 15 : 0;
            phase_end = sent_chars + 165;
            while (sent_chars < phase_end) begin
                if (strings_done == 2 || $urandom_range(0, 11) == 0) drain();
                nseg = $urandom_range(1, 8);
                repeat (nseg - 1) push_segment(1'b1);
                push_segment(1'($urandom_range(0, 1)));
                push_char(CH_TERM);
                gen_src  = '0;
                gen_name = '0;
                strings_done++;
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
sv/smmd_pkg.sv
sv/smmd_core.sv
sv/source_map_mapping_decoder.sv
sv/smmd_checker.sv
tb/testbench.sv
